// File: rtl/ssdb_pkg.sv
// ssdb_pkg: shared types, command codes and the character table of the
// seven-segment display unit. No dependencies.
`timescale 1ns / 1ps

package ssdb_pkg;

   localparam int NUM_DIGITS = 4;
   localparam int NUM_POSITIONS = NUM_DIGITS + 1;
   localparam int TABLE_SIZE = 36;

   localparam logic [2:0] CMD_WRITE_NUMBER = 3'd0;
   localparam logic [2:0] CMD_BLINK_TICK   = 3'd1;
   localparam logic [2:0] CMD_REFRESH      = 3'd2;
   localparam logic [2:0] CMD_SET_DOTS     = 3'd3;
   localparam logic [2:0] CMD_SET_MASK     = 3'd4;

   localparam logic [2:0] POS_DOTS = 3'd4;

   localparam logic [7:0] CODE_BLANK = 8'h80;
   localparam logic [7:0] CODE_MINUS = 8'hC0;
   localparam logic [7:0] CODE_NINE  = 8'd9;
   localparam logic [7:0] ALL_ON     = 8'hFF;

   localparam logic signed [15:0] MAX_SHOWN = 16'sd9999;
   localparam logic signed [15:0] MIN_SHOWN = -16'sd999;

   // reciprocal of ten for magnitudes below 2^14: floor(x * 6554 / 2^16)
   localparam logic [12:0] RECIP_TEN = 13'd6554;

   localparam logic [0:0] REG_TOGGLE_PERIOD = 1'b0;
   localparam logic [7:0] TOGGLE_PERIOD_RESET = 8'd50;

   localparam logic [7:0] GLYPHS [TABLE_SIZE] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
      8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76, 8'h30, 8'h0E,
      8'h00, 8'h38, 8'h00, 8'h54, 8'h3F, 8'h73, 8'h00, 8'h50, 8'h6D, 8'h31,
      8'h3E, 8'h00, 8'h00, 8'h00, 8'h6E, 8'h5B
   };

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_CONVERT
   } state_type;

   typedef struct packed {
      logic accept;
      logic conv_step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic start_conv;
      logic conv_done;
      logic out_free;
   } dp_status_type;

   function automatic logic [7:0] code_to_segments(input logic [7:0] code);
      logic [7:0] seg;
      seg = 8'h00;
      if (code[7]) begin
         seg = code;
      end else if (code < 8'(TABLE_SIZE)) begin
         seg = GLYPHS[code[5:0]];
      end
      return seg;
   endfunction

endpackage

// File: rtl/ssdb_req_if.sv
// ssdb_req_if: command channel of the display unit, valid/ready plus payload.
// No dependencies.
`timescale 1ns / 1ps

interface ssdb_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         cmd;
   logic signed [15:0] value;
   logic [2:0]         position;
   logic [7:0]         dot_bits;
   logic [7:0]         mask_bits;

   modport source (output valid, cmd, value, position, dot_bits, mask_bits,
                   input ready);
   modport sink (input valid, cmd, value, position, dot_bits, mask_bits,
                 output ready);
endinterface

// File: rtl/ssdb_rsp_if.sv
// ssdb_rsp_if: segment result channel of the display unit, valid/ready plus
// payload. No dependencies.
`timescale 1ns / 1ps

interface ssdb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] segments;

   modport source (output valid, segments, input ready);
   modport sink (input valid, segments, output ready);
endinterface

// File: rtl/seven_segment_display_with_blink_unit.sv
// seven_segment_display_with_blink_unit: top level, csr register, controller
// and datapath. Depends on ssdb_pkg, ssdb_req_if, ssdb_rsp_if, ssdb_ctrl,
// ssdb_datapath.
`timescale 1ns / 1ps

// four-digit seven-segment display store driven by command items
// req_bus carries one command item: write number, blink tick, refresh
//   position, set dots or set blink mask, taken when valid and ready are high
// rsp_bus carries one segment byte for each refresh of positions 0..4;
//   no other command gives an item
// latency: a refresh result is shown in the cycle after acceptance
// throughput: one item per cycle while the output register is free, for all
//   commands except a write number that needs decimal conversion; that one
//   converts one decimal digit per step (reciprocal multiply by ten) and then
//   takes a closing step, with ready low after the accept cycle
// a result waiting in the output register blocks every new item until the
//   receiver takes it; ready comes back in the cycle the receiver is ready
// csr port: toggle_period at byte address 0, writes in the access phase,
//   pready always high, reads return the stored value
// reset (synchronous): digits blank, dots and masks clear, all segments
//   visible, blink counter zero, toggle_period 50; no clearing pass

module seven_segment_display_with_blink_unit (
   input  logic              clock,
   input  logic              reset,
   ssdb_req_if.sink          req_bus,
   ssdb_rsp_if.source        rsp_bus,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   ssdb_pkg::ctrl_cmd_type  ctrl_cmd;
   ssdb_pkg::dp_status_type dp_status;

   logic [7:0] toggle_period_ff;
   logic [7:0] toggle_period_in;
   logic       csr_write;
   logic       req_ready;

   // register select is address bit 2, the low address bits are ignored
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      toggle_period_in = toggle_period_ff;
      if (csr_write && paddr[2] == ssdb_pkg::REG_TOGGLE_PERIOD) begin
         toggle_period_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         toggle_period_ff <= ssdb_pkg::TOGGLE_PERIOD_RESET;
      end else begin
         toggle_period_ff <= toggle_period_in;
      end
   end

   assign prdata = (paddr[2] == ssdb_pkg::REG_TOGGLE_PERIOD) ?
                   {24'h000000, toggle_period_ff} : 32'h00000000;

   // sequencer: idle accepts items, convert steps the digit loop
   ssdb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   assign req_bus.ready = req_ready;

   // display state, conversion and output register
   ssdb_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .item_cmd       (req_bus.cmd),
      .item_value     (req_bus.value),
      .item_position  (req_bus.position),
      .item_dot_bits  (req_bus.dot_bits),
      .item_mask_bits (req_bus.mask_bits),
      .toggle_period  (toggle_period_ff),
      .cmd            (ctrl_cmd),
      .status         (dp_status),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_segments   (rsp_bus.segments)
   );

   // refresh of a real position gives a result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_ready && req_bus.cmd == ssdb_pkg::CMD_REFRESH &&
       req_bus.position <= ssdb_pkg::POS_DOTS) |=> rsp_bus.valid)
      else $error("refresh item gave no result");

   // a conversion blocks new items in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      (ctrl_cmd.accept && dp_status.start_conv) |=> !req_ready)
      else $error("item accepted during conversion");

   // a new result only follows an accepted refresh
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |->
         $past(ctrl_cmd.accept && req_bus.cmd == ssdb_pkg::CMD_REFRESH))
      else $error("result without refresh item");

   // no item is taken while the output register is full and not drained
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |-> !req_ready)
      else $error("item accepted with output register full");

endmodule

// File: rtl/ssdb_ctrl.sv
// ssdb_ctrl: controller state machine of the display unit.
// Depends on ssdb_pkg.
`timescale 1ns / 1ps

module ssdb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ssdb_pkg::dp_status_type status,
   output ssdb_pkg::ctrl_cmd_type  cmd
);

   ssdb_pkg::state_type state_ff;
   ssdb_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssdb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd.accept    = 1'b0;
      cmd.conv_step = 1'b0;
      unique case (state_ff)
         ssdb_pkg::ST_IDLE: begin
            req_ready  = !reset && status.out_free;
            cmd.accept = req_valid && req_ready;
            if (cmd.accept && status.start_conv) begin
               state_in = ssdb_pkg::ST_CONVERT;
            end
         end
         ssdb_pkg::ST_CONVERT: begin
            cmd.conv_step = 1'b1;
            if (status.conv_done) begin
               state_in = ssdb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ssdb_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/ssdb_datapath.sv
// ssdb_datapath: display state, digit conversion by reciprocal multiply,
// blink logic and the result register. Depends on ssdb_pkg.
`timescale 1ns / 1ps

module ssdb_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [2:0]             item_cmd,
   input  logic signed [15:0]     item_value,
   input  logic [2:0]             item_position,
   input  logic [7:0]             item_dot_bits,
   input  logic [7:0]             item_mask_bits,
   input  logic [7:0]             toggle_period,
   input  ssdb_pkg::ctrl_cmd_type  cmd,
   output ssdb_pkg::dp_status_type status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_segments
);

   localparam int NP = ssdb_pkg::NUM_POSITIONS;
   localparam int ND = ssdb_pkg::NUM_DIGITS;

   logic [7:0]  codes_ff [ND];
   logic [7:0]  codes_in [ND];
   logic [7:0]  dots_ff, dots_in;
   logic [7:0]  masks_ff [NP];
   logic [7:0]  masks_in [NP];
   logic [7:0]  phase_ff [NP];
   logic [7:0]  phase_in [NP];
   logic [7:0]  count_ff, count_in;
   logic [13:0] mag_ff, mag_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic [7:0]  seg_ff, seg_in;
   logic        valid_ff, valid_in;

   logic [26:0]        prod;
   logic [10:0]        quo;
   logic [13:0]        quo_ten;
   logic [3:0]         rem;
   logic [1:0]         digit_pos;
   logic [7:0]         count_next;
   logic signed [15:0] neg_value;
   logic               in_range;

   // one decimal digit per step
   assign prod      = {13'd0, mag_ff} * {14'd0, ssdb_pkg::RECIP_TEN};
   assign quo       = prod[26:16];
   assign quo_ten   = {quo[10:0], 3'b000} + {2'b00, quo[10:0], 1'b0};
   assign rem       = 4'(mag_ff - quo_ten);
   assign digit_pos = 2'(3'(ND - 1) - cnt_ff);
   assign neg_value = -item_value;
   assign in_range  = (item_value <= ssdb_pkg::MAX_SHOWN) &&
                      (item_value >= ssdb_pkg::MIN_SHOWN);
   assign count_next = count_ff + 8'd1;

   assign status.start_conv = (item_cmd == ssdb_pkg::CMD_WRITE_NUMBER) &&
                              (item_value != 16'sd0) && in_range;
   assign status.conv_done  = (mag_ff == 14'd0) || (cnt_ff == 3'(ND));
   assign status.out_free   = !valid_ff || rsp_ready;

   always_comb begin
      codes_in = codes_ff;
      dots_in  = dots_ff;
      masks_in = masks_ff;
      phase_in = phase_ff;
      count_in = count_ff;
      mag_in   = mag_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      seg_in   = seg_ff;
      valid_in = valid_ff && !rsp_ready;

      if (cmd.conv_step) begin
         if (!status.conv_done) begin
            codes_in[digit_pos] = {4'b0000, rem};
            mag_in = {3'b000, quo};
            cnt_in = cnt_ff + 3'd1;
         end else if (neg_ff && cnt_ff != 3'(ND)) begin
            codes_in[digit_pos] = ssdb_pkg::CODE_MINUS;
         end
      end

      if (cmd.accept) begin
         unique case (item_cmd)
            ssdb_pkg::CMD_WRITE_NUMBER: begin
               dots_in = 8'h00;
               for (int j = 0; j < ND; j++) begin
                  codes_in[j] = ssdb_pkg::CODE_BLANK;
               end
               for (int j = 0; j < NP; j++) begin
                  masks_in[j] = 8'h00;
                  phase_in[j] = ssdb_pkg::ALL_ON;
               end
               if (item_value == 16'sd0) begin
                  codes_in[ND-1] = 8'd0;
               end else if (!in_range) begin
                  for (int j = 0; j < ND; j++) begin
                     codes_in[j] = ssdb_pkg::CODE_NINE;
                     masks_in[j] = ssdb_pkg::ALL_ON;
                  end
                  if (item_value[15]) begin
                     codes_in[0] = ssdb_pkg::CODE_MINUS;
                  end
               end else begin
                  mag_in = item_value[15] ? neg_value[13:0] : item_value[13:0];
                  neg_in = item_value[15];
                  cnt_in = 3'd0;
               end
            end
            ssdb_pkg::CMD_BLINK_TICK: begin
               count_in = count_next;
               if (count_next >= toggle_period) begin
                  count_in = 8'd0;
                  for (int j = 0; j < NP; j++) begin
                     phase_in[j] = (phase_ff[j] ^ masks_ff[j]) | ~masks_ff[j];
                  end
               end
            end
            ssdb_pkg::CMD_REFRESH: begin
               if (item_position == ssdb_pkg::POS_DOTS) begin
                  seg_in   = dots_ff & phase_ff[item_position];
                  valid_in = 1'b1;
               end else if (item_position < ssdb_pkg::POS_DOTS) begin
                  seg_in = ssdb_pkg::code_to_segments(codes_ff[item_position[1:0]]) &
                           phase_ff[item_position];
                  valid_in = 1'b1;
               end
            end
            ssdb_pkg::CMD_SET_DOTS: begin
               dots_in = item_dot_bits;
            end
            ssdb_pkg::CMD_SET_MASK: begin
               if (item_position <= ssdb_pkg::POS_DOTS) begin
                  masks_in[item_position] = item_mask_bits;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < ND; j++) begin
            codes_ff[j] <= ssdb_pkg::CODE_BLANK;
         end
         for (int j = 0; j < NP; j++) begin
            masks_ff[j] <= 8'h00;
            phase_ff[j] <= ssdb_pkg::ALL_ON;
         end
         dots_ff  <= 8'h00;
         count_ff <= 8'd0;
         valid_ff <= 1'b0;
      end else begin
         codes_ff <= codes_in;
         masks_ff <= masks_in;
         phase_ff <= phase_in;
         dots_ff  <= dots_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      seg_ff <= seg_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_segments = seg_ff;

endmodule

// File: test/seven_segment_display_with_blink_unit_tb.sv
// seven_segment_display_with_blink_unit_tb: self-checking bench that sends command items to the
// display unit and checks every refresh item against an in-bench display predictor.
// Depends on ssdb_pkg, ssdb_req_if, ssdb_rsp_if and seven_segment_display_with_blink_unit.
`timescale 1ns / 1ps

module seven_segment_display_with_blink_unit_tb;

   // long receiver hold-off, in cycles
   localparam int LONG_HOLD = 200;
   // a write number keeps the unit busy through its conversion with no item out
   localparam int DRAIN_CYCLES = 10;
   // cycles in a row with no handshake at all before the run is given up
   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic [2:0] TOGGLE_PERIOD_ADDR = 3'(4 * ssdb_pkg::REG_TOGGLE_PERIOD);
   localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] CMD_UNUSED_MID   = 3'd6;
   localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;
   localparam logic [2:0] POS_LAST_VALID   = ssdb_pkg::POS_DOTS;
   localparam logic [2:0] POS_LAST         = 3'd7;

   // segment patterns of codes 0..9 and the letters that follow
   localparam logic [7:0] SEGMENT_ROM [ssdb_pkg::TABLE_SIZE] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
      8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76, 8'h30, 8'h0E,
      8'h00, 8'h38, 8'h00, 8'h54, 8'h3F, 8'h73, 8'h00, 8'h50, 8'h6D, 8'h31,
      8'h3E, 8'h00, 8'h00, 8'h00, 8'h6E, 8'h5B
   };

   // numbers on and around the edges of what the display can show
   localparam int EDGE_VALUES [12] = '{
      0, 1, -1, 9, 10, 9999, 10000, -999, -1000, -99, -32768, 32767
   };

   typedef struct {
      logic [2:0]         cmd;
      logic signed [15:0] value;
      logic [2:0]         position;
      logic [7:0]         dot_bits;
      logic [7:0]         mask_bits;
   } display_cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   ssdb_req_if req_bus ();
   ssdb_rsp_if rsp_bus ();

   seven_segment_display_with_blink_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #5 clock = ~clock;

   // command items waiting to be offered, segment bytes waiting to come out
   display_cmd_type  pending_cmds [$];
   logic [7:0]       expected_segments [$];
   display_cmd_type  offered_cmd;

   // predicted display state
   logic [7:0] shown_codes [ssdb_pkg::NUM_DIGITS];
   logic [7:0] dot_segments;
   logic [7:0] blink_sel [ssdb_pkg::NUM_POSITIONS];
   logic [7:0] blink_phase [ssdb_pkg::NUM_POSITIONS];
   logic [7:0] tick_count;
   logic [7:0] toggle_period_q;

   int mismatch_count = 0;
   int idle_odds = 0;       // one idle burst in idle_odds chances, 0 means never
   int hold_requests = 0;   // bumped to ask the receiver for one long hold-off
   int holds_served = 0;
   int sender_gap = 0;
   int receiver_gap = 0;
   int stall_cycles = 0;

   // ------------------------------------------------------------------
   // display predictor
   // ------------------------------------------------------------------

   function automatic void blank_display();
      dot_segments = '0;
      for (int d = 0; d < ssdb_pkg::NUM_DIGITS; d++) begin
         shown_codes[d] = ssdb_pkg::CODE_BLANK;
      end
      for (int p = 0; p < ssdb_pkg::NUM_POSITIONS; p++) begin
         blink_sel[p] = '0;
         blink_phase[p] = ssdb_pkg::ALL_ON;
      end
   endfunction

   // applies one accepted command item, gives the segment byte for a refresh
   function automatic void apply_display_command(input display_cmd_type c,
                                                 output bit has_result,
                                                 output logic [7:0] seg);
      int num;
      int mag;
      int slot;
      logic [7:0] code;
      has_result = 1'b0;
      seg = '0;
      case (c.cmd)
         ssdb_pkg::CMD_WRITE_NUMBER: begin
            num = c.value;
            blank_display();
            if (num == 0) begin
               // zero is a single 0 at the right
               shown_codes[ssdb_pkg::NUM_DIGITS - 1] = 8'd0;
            end else if (num > int'(ssdb_pkg::MAX_SHOWN) ||
                         num < int'(ssdb_pkg::MIN_SHOWN)) begin
               // out of range: all nines, all digits blink, minus first if negative
               for (int d = 0; d < ssdb_pkg::NUM_DIGITS; d++) begin
                  shown_codes[d] = ssdb_pkg::CODE_NINE;
                  blink_sel[d] = ssdb_pkg::ALL_ON;
               end
               if (num < 0) begin
                  shown_codes[0] = ssdb_pkg::CODE_MINUS;
               end
            end else begin
               mag = (num < 0) ? -num : num;
               slot = ssdb_pkg::NUM_DIGITS - 1;
               while (mag > 0 && slot >= 0) begin
                  shown_codes[slot] = 8'(mag % 10);
                  mag = mag / 10;
                  slot--;
               end
               if (num < 0 && slot >= 0) begin
                  shown_codes[slot] = ssdb_pkg::CODE_MINUS;
               end
            end
         end
         ssdb_pkg::CMD_BLINK_TICK: begin
            tick_count = tick_count + 8'd1;
            if (tick_count >= toggle_period_q) begin
               tick_count = '0;
               for (int p = 0; p < ssdb_pkg::NUM_POSITIONS; p++) begin
                  blink_phase[p] = (blink_phase[p] ^ blink_sel[p]) | ~blink_sel[p];
               end
            end
         end
         ssdb_pkg::CMD_REFRESH: begin
            if (c.position == ssdb_pkg::POS_DOTS) begin
               has_result = 1'b1;
               seg = dot_segments & blink_phase[ssdb_pkg::NUM_DIGITS];
            end else if (c.position < ssdb_pkg::POS_DOTS) begin
               has_result = 1'b1;
               code = shown_codes[c.position];
               if (code[7]) begin
                  seg = code;
               end else if (code < 8'(ssdb_pkg::TABLE_SIZE)) begin
                  seg = SEGMENT_ROM[code];
               end
               seg = seg & blink_phase[c.position];
            end
         end
         ssdb_pkg::CMD_SET_DOTS: begin
            dot_segments = c.dot_bits;
         end
         ssdb_pkg::CMD_SET_MASK: begin
            if (c.position <= POS_LAST_VALID) begin
               blink_sel[c.position] = c.mask_bits;
            end
         end
         default: begin
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   function automatic void queue_cmd(input logic [2:0] cmd, input int value,
                                     input logic [2:0] position, input logic [7:0] dot_bits,
                                     input logic [7:0] mask_bits);
      display_cmd_type c;
      c.cmd = cmd;
      c.value = 16'(value);
      c.position = position;
      c.dot_bits = dot_bits;
      c.mask_bits = mask_bits;
      pending_cmds.push_back(c);
   endfunction

   // mostly real positions, now and then one that must be ignored
   function automatic logic [2:0] pick_position();
      if ($urandom_range(0, 9) == 0) begin
         return 3'($urandom_range(POS_LAST_VALID + 1, POS_LAST));
      end
      return 3'($urandom_range(0, POS_LAST_VALID));
   endfunction

   function automatic int pick_number();
      int n;
      case ($urandom_range(0, 5))
         0: n = $urandom_range(0, 9999);
         1: n = 0 - int'($urandom_range(1, 999));
         2: n = $urandom_range(0, 20);
         3: n = EDGE_VALUES[$urandom_range(0, 11)];
         4: n = int'($urandom_range(0, 65535)) - 32768;
         default: n = $urandom_range(0, 99);
      endcase
      return n;
   endfunction

   // tick_pct of the items are blink ticks; writes, masks, dots and unused codes
   // take a fixed share and refreshes fill up the rest
   function automatic void queue_random_cmds(input int count, input int tick_pct);
      int r;
      display_cmd_type c;
      for (int k = 0; k < count; k++) begin
         c.cmd = ssdb_pkg::CMD_REFRESH;
         c.value = 16'($urandom);
         c.position = 3'($urandom);
         c.dot_bits = 8'($urandom);
         c.mask_bits = 8'($urandom);
         r = $urandom_range(0, 99);
         if (r < 8) begin
            c.cmd = ssdb_pkg::CMD_WRITE_NUMBER;
            c.value = 16'(pick_number());
         end else if (r < 20) begin
            c.cmd = ssdb_pkg::CMD_SET_MASK;
            c.position = pick_position();
         end else if (r < 26) begin
            c.cmd = ssdb_pkg::CMD_SET_DOTS;
         end else if (r < 30) begin
            c.cmd = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
         end else if (r < 30 + tick_pct) begin
            c.cmd = ssdb_pkg::CMD_BLINK_TICK;
         end else begin
            c.position = pick_position();
         end
         pending_cmds.push_back(c);
      end
   endfunction

   // waits until every item went in and every segment byte came out,
   // then lets a write number still in conversion finish
   task automatic wait_until_drained();
      do begin
         @(negedge clock);
      end while (pending_cmds.size() != 0 || req_bus.valid || expected_segments.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_toggle_period(input logic [7:0] speed);
      wait_until_drained();
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= TOGGLE_PERIOD_ADDR;
      pwdata <= 32'(speed);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      toggle_period_q = speed;
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // command driver: predicts each accepted item, then offers the next one
   // ------------------------------------------------------------------

   always @(posedge clock) begin : drive_commands
      bit has_seg;
      logic [7:0] seg;
      if (reset) begin
         req_bus.valid <= 1'b0;
         sender_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            apply_display_command(offered_cmd, has_seg, seg);
            if (has_seg) begin
               expected_segments.push_back(seg);
            end
         end
         // slot is free when nothing is offered or the offer was just taken
         if (!req_bus.valid || req_bus.ready) begin
            if (sender_gap > 0) begin
               sender_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_cmds.size() != 0 && idle_odds != 0
                         && $urandom_range(1, idle_odds) == 1) begin
               sender_gap = $urandom_range(0, 3);
               req_bus.valid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
               offered_cmd = pending_cmds.pop_front();
               req_bus.cmd <= offered_cmd.cmd;
               req_bus.value <= offered_cmd.value;
               req_bus.position <= offered_cmd.position;
               req_bus.dot_bits <= offered_cmd.dot_bits;
               req_bus.mask_bits <= offered_cmd.mask_bits;
               req_bus.valid <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // segment receiver: random short stalls, and long hold-offs on request
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         receiver_gap = 0;
      end else if (hold_requests != holds_served) begin
         holds_served++;
         receiver_gap = LONG_HOLD - 1;
         rsp_bus.ready <= 1'b0;
      end else if (receiver_gap > 0) begin
         receiver_gap--;
         rsp_bus.ready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         receiver_gap = $urandom_range(0, 3);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // segment checker: every item out must match the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_segments.size() == 0) begin
            $error("segments: no item expected, actual %02h", rsp_bus.segments);
            mismatch_count++;
         end else if (rsp_bus.segments !== expected_segments[0]) begin
            $error("segments mismatch: expected %02h, actual %02h",
                   expected_segments[0], rsp_bus.segments);
            mismatch_count++;
            void'(expected_segments.pop_front());
         end else begin
            void'(expected_segments.pop_front());
         end
      end
   end

   // watchdog on cycles with no handshake on any port
   always @(posedge clock) begin
      if (reset || psel || (req_bus.valid && req_bus.ready)
          || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------

   initial begin
      req_bus.valid = 1'b0;
      req_bus.cmd = ssdb_pkg::CMD_BLINK_TICK;
      req_bus.value = '0;
      req_bus.position = '0;
      req_bus.dot_bits = '0;
      req_bus.mask_bits = '0;
      rsp_bus.ready = 1'b0;
      toggle_period_q = ssdb_pkg::TOGGLE_PERIOD_RESET;
      tick_count = '0;
      blank_display();
      idle_odds = 6;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset state, ignored positions and unused codes
      queue_cmd(ssdb_pkg::CMD_REFRESH, 0, 3'd0, 8'h00, 8'h00);
      queue_cmd(ssdb_pkg::CMD_REFRESH, 0, ssdb_pkg::POS_DOTS, 8'hFF, 8'hFF);
      queue_cmd(ssdb_pkg::CMD_REFRESH, 0, POS_LAST, 8'h00, 8'h00);
      queue_cmd(CMD_UNUSED_FIRST, 0, 3'd0, 8'hFF, 8'hFF);
      queue_cmd(CMD_UNUSED_MID, -1, 3'd2, 8'hFF, 8'hFF);
      queue_cmd(CMD_UNUSED_LAST, 32767, POS_LAST, 8'hFF, 8'hFF);
      // zero, the extreme values and the edges of the shown range
      queue_cmd(ssdb_pkg::CMD_WRITE_NUMBER, 0, 3'd0, 8'h00, 8'h00);
      queue_cmd(ssdb_pkg::CMD_REFRESH, 0, 3'd3, 8'h00, 8'h00);
      queue_cmd(ssdb_pkg::CMD_REFRESH, 0, 3'd2, 8'h00, 8'h00);
      queue_cmd(ssdb_pkg::CMD_WRITE_NUMBER, -32768, 3'd0, 8'h00, 8'h00);
      queue_cmd(ssdb_pkg::CMD_REFRESH, 0, 3'd0, 8'h00, 8'h00);
      queue_cmd(ssdb_pkg::CMD_REFRESH, 0, 3'd1, 8'h00, 8'h00);
      queue_cmd(ssdb_pkg::CMD_WRITE_NUMBER, 32767, 3'd0, 8'h00, 8'h00);
      queue_cmd(ssdb_pkg::CMD_REFRESH, 0, 3'd0, 8'h00, 8'h00);
      queue_cmd(ssdb_pkg::CMD_WRITE_NUMBER, -999, 3'd0, 8'h00, 8'h00);
      queue_cmd(ssdb_pkg::CMD_REFRESH, 0, 3'd0, 8'h00, 8'h00);
      queue_cmd(ssdb_pkg::CMD_WRITE_NUMBER, 9999, 3'd0, 8'h00, 8'h00);
      queue_cmd(ssdb_pkg::CMD_REFRESH, 0, 3'd0, 8'h00, 8'h00);
      queue_cmd(ssdb_pkg::CMD_SET_DOTS, 0, 3'd0, 8'hFF, 8'h00);
      queue_cmd(ssdb_pkg::CMD_REFRESH, 0, ssdb_pkg::POS_DOTS, 8'h00, 8'h00);

      // zero blink speed: every tick toggles; masks at the dots and at an ignored position
      write_toggle_period(8'd0);
      queue_cmd(ssdb_pkg::CMD_SET_MASK, 0, ssdb_pkg::POS_DOTS, 8'h00, 8'h0F);
      queue_cmd(ssdb_pkg::CMD_SET_MASK, 0, 3'd6, 8'h00, 8'hFF);
      queue_cmd(ssdb_pkg::CMD_BLINK_TICK, 0, 3'd0, 8'h00, 8'h00);
      queue_cmd(ssdb_pkg::CMD_REFRESH, 0, ssdb_pkg::POS_DOTS, 8'h00, 8'h00);
      queue_cmd(ssdb_pkg::CMD_WRITE_NUMBER, 10000, 3'd0, 8'h00, 8'h00);
      queue_cmd(ssdb_pkg::CMD_BLINK_TICK, 0, 3'd0, 8'h00, 8'h00);
      queue_cmd(ssdb_pkg::CMD_REFRESH, 0, 3'd0, 8'h00, 8'h00);
      queue_cmd(ssdb_pkg::CMD_REFRESH, 0, ssdb_pkg::POS_DOTS, 8'h00, 8'h00);
      queue_cmd(ssdb_pkg::CMD_WRITE_NUMBER, -1000, 3'd0, 8'h00, 8'h00);
      queue_cmd(ssdb_pkg::CMD_BLINK_TICK, 0, 3'd0, 8'h00, 8'h00);
      queue_cmd(ssdb_pkg::CMD_REFRESH, 0, 3'd0, 8'h00, 8'h00);

      // fastest blinking, with the receiver holding off long enough to stall input
      write_toggle_period(8'd1);
      hold_requests++;
      queue_random_cmds(300, 30);

      // slowest blinking, tick heavy so that the count gets all the way round
      write_toggle_period(8'd255);
      idle_odds = 4;
      queue_random_cmds(550, 50);

      // some middle speed under heavy idling on both sides
      write_toggle_period(8'($urandom_range(2, 9)));
      idle_odds = 3;
      queue_random_cmds(250, 35);

      // last part runs at full rate
      write_toggle_period(8'($urandom_range(2, 9)));
      idle_odds = 0;
      queue_random_cmds(150, 35);

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && expected_segments.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/ssdb_pkg.sv
rtl/ssdb_req_if.sv
rtl/ssdb_rsp_if.sv
rtl/ssdb_ctrl.sv
rtl/ssdb_datapath.sv
rtl/seven_segment_display_with_blink_unit.sv
test/seven_segment_display_with_blink_unit_tb.sv
